// ===== rtl/mwm_pkg.sv =====
package mwm_pkg;

  localparam int FRACTION_BITS_DEF = 8;

  localparam int AXES       = 3;
  localparam int WHEELS     = 4;
  localparam int QUOT_BITS  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // queue depths, powers of two
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  localparam logic [6:0] DEAD_BAND_RST    = 7'd10;
  localparam logic [8:0] FORWARD_GAIN_RST = 9'd205;
  localparam logic [8:0] STRAFE_GAIN_RST  = 9'd205;
  localparam logic [8:0] ROTATE_GAIN_RST  = 9'd154;
  localparam logic [6:0] POWER_LIMIT_RST  = 7'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_BAND    = 3'd0,
    REG_FORWARD_GAIN = 3'd1,
    REG_STRAFE_GAIN  = 3'd2,
    REG_ROTATE_GAIN  = 3'd3,
    REG_POWER_LIMIT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [6:0] dead_band;
    logic [8:0] forward_gain;
    logic [8:0] strafe_gain;
    logic [8:0] rotate_gain;
    logic [6:0] power_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0] wheel_fl;
    logic signed [7:0] wheel_fr;
    logic signed [7:0] wheel_rl;
    logic signed [7:0] wheel_rr;
    logic              was_scaled;
  } result_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_PUSH = 2'd2
  } back_state_t;

  // shaped axis, signed
  function automatic int axis_w(int fb);
    return fb + 9;
  endfunction

  // mixed wheel power, signed
  function automatic int pow_w(int fb);
    return fb + 11;
  endfunction

  // wheel power magnitude, unsigned
  function automatic int mag_w(int fb);
    return fb + 10;
  endfunction

  // magnitude times power limit
  function automatic int div_w(int fb);
    return mag_w(fb) + 7;
  endfunction

  // queue entry: halt, scaled, max magnitude, four powers
  function automatic int mid_w(int fb);
    return 2 + mag_w(fb) + WHEELS * pow_w(fb);
  endfunction

endpackage

// ===== rtl/mwm_fifo.sv =====
module mwm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic [WIDTH-1:0]               wr_data,
  output logic                           full,
  input  logic                           pop,
  output logic [WIDTH-1:0]               rd_data,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rd_data = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== rtl/mwm_front.sv =====
module mwm_front #(
  parameter int FRACTION_BITS = mwm_pkg::FRACTION_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_valid,
  input  logic signed [7:0]                           forward_axis,
  input  logic signed [7:0]                           strafe_axis,
  input  logic signed [7:0]                           rotate_axis,
  input  logic                                        halt,
  input  mwm_pkg::cfg_t                               cfg,
  output logic                                        out_valid,
  output logic [mwm_pkg::mid_w(FRACTION_BITS)-1:0]    out_data,
  output logic [1:0]                                  in_flight
);

  localparam int FB  = FRACTION_BITS;
  localparam int AXW = mwm_pkg::axis_w(FB);
  localparam int PW  = mwm_pkg::pow_w(FB);
  localparam int MW  = mwm_pkg::mag_w(FB);

  logic signed [7:0]     axis_raw  [mwm_pkg::AXES];
  logic [8:0]            axis_gain [mwm_pkg::AXES];
  logic signed [AXW-1:0] axis_q    [mwm_pkg::AXES];

  logic                  v1_r;
  logic                  halt1_r;
  logic signed [AXW-1:0] ax1_r [mwm_pkg::AXES];

  logic signed [PW-1:0]  p_nxt  [mwm_pkg::WHEELS];
  logic [MW-1:0]         mg_nxt [mwm_pkg::WHEELS];

  logic                  v2_r;
  logic                  halt2_r;
  logic signed [PW-1:0]  p2_r  [mwm_pkg::WHEELS];
  logic [MW-1:0]         mg2_r [mwm_pkg::WHEELS];

  logic [MW-1:0]         max_a;
  logic [MW-1:0]         max_b;
  logic [MW-1:0]         max_m;
  logic                  scaled;

  assign axis_raw[0]  = forward_axis;
  assign axis_raw[1]  = strafe_axis;
  assign axis_raw[2]  = rotate_axis;
  assign axis_gain[0] = cfg.forward_gain;
  assign axis_gain[1] = cfg.strafe_gain;
  assign axis_gain[2] = cfg.rotate_gain;

  // stage 1: dead band, gain, move to the working fraction width
  for (genvar g = 0; g < mwm_pkg::AXES; g++) begin : g_axis
    logic [8:0]         amag;
    logic signed [7:0]  az;
    logic signed [17:0] prod;

    assign amag = axis_raw[g][7] ? (9'd0 - {1'b1, axis_raw[g]}) : {1'b0, axis_raw[g]};
    assign az   = (amag < {2'b00, cfg.dead_band}) ? '0 : axis_raw[g];
    assign prod = az * $signed({1'b0, axis_gain[g]});

    if (FB >= 8) begin : g_up
      assign axis_q[g] = AXW'(prod) <<< (FB - 8);
    end else begin : g_dn
      localparam int SH = 8 - FB;
      logic signed [17:0] bias;
      logic signed [17:0] biased;
      // round toward zero before the arithmetic shift
      assign bias      = prod[17] ? 18'((1 << SH) - 1) : '0;
      assign biased    = prod + bias;
      assign axis_q[g] = AXW'(biased >>> SH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      halt1_r <= halt;
      ax1_r   <= axis_q;
    end
  end

  // stage 2: mecanum mix and magnitudes
  always_comb begin
    p_nxt[0] = PW'(ax1_r[0]) + PW'(ax1_r[1]) + PW'(ax1_r[2]);
    p_nxt[1] = PW'(ax1_r[0]) - PW'(ax1_r[1]) - PW'(ax1_r[2]);
    p_nxt[2] = PW'(ax1_r[0]) - PW'(ax1_r[1]) + PW'(ax1_r[2]);
    p_nxt[3] = PW'(ax1_r[0]) + PW'(ax1_r[1]) - PW'(ax1_r[2]);
    for (int i = 0; i < mwm_pkg::WHEELS; i++) begin
      mg_nxt[i] = p_nxt[i][PW-1] ? MW'(-p_nxt[i]) : MW'(p_nxt[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      halt2_r <= halt1_r;
      p2_r    <= p_nxt;
      mg2_r   <= mg_nxt;
    end
  end

  // largest magnitude and the normalize decision
  assign max_a  = (mg2_r[0] > mg2_r[1]) ? mg2_r[0] : mg2_r[1];
  assign max_b  = (mg2_r[2] > mg2_r[3]) ? mg2_r[2] : mg2_r[3];
  assign max_m  = (max_a > max_b) ? max_a : max_b;
  assign scaled = !halt2_r && (max_m > MW'({cfg.power_limit, {FB{1'b0}}}));

  assign out_valid = v2_r;
  assign out_data  = {halt2_r, scaled, max_m, p2_r[0], p2_r[1], p2_r[2], p2_r[3]};
  assign in_flight = {1'b0, v1_r} + {1'b0, v2_r};

endmodule

// ===== rtl/mwm_back.sv =====
module mwm_back #(
  parameter int FRACTION_BITS = mwm_pkg::FRACTION_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        mid_empty,
  input  logic [mwm_pkg::mid_w(FRACTION_BITS)-1:0]    mid_data,
  output logic                                        mid_pop,
  input  logic [6:0]                                  power_limit,
  input  logic                                        res_full,
  output logic                                        res_push,
  output mwm_pkg::result_t                            res
);

  localparam int FB   = FRACTION_BITS;
  localparam int PW   = mwm_pkg::pow_w(FB);
  localparam int MW   = mwm_pkg::mag_w(FB);
  localparam int DW   = mwm_pkg::div_w(FB);
  localparam int MIDW = mwm_pkg::mid_w(FB);
  localparam int QB   = mwm_pkg::QUOT_BITS;
  localparam int SW   = $clog2(QB);

  mwm_pkg::back_state_t state_r, state_nxt;

  logic                 e_halt;
  logic                 e_scaled;
  logic [MW-1:0]        e_max;
  logic signed [PW-1:0] e_p [mwm_pkg::WHEELS];

  logic [DW-1:0]        dvd_nxt [mwm_pkg::WHEELS];
  logic [7:0]           trunc_w [mwm_pkg::WHEELS];
  logic [7:0]           div_w   [mwm_pkg::WHEELS];
  logic                 ge      [mwm_pkg::WHEELS];

  logic [DW-1:0]        rem_r  [mwm_pkg::WHEELS];
  logic [QB-1:0]        quot_r [mwm_pkg::WHEELS];
  logic                 neg_r  [mwm_pkg::WHEELS];
  logic [DW-1:0]        dsh_r;
  logic [SW-1:0]        step_r;

  logic                 load;
  logic                 step;
  mwm_pkg::result_t     res_trunc;
  mwm_pkg::result_t     res_div;

  assign e_halt   = mid_data[MIDW-1];
  assign e_scaled = mid_data[MIDW-2];
  assign e_max    = mid_data[MIDW-3 -: MW];

  for (genvar i = 0; i < mwm_pkg::WHEELS; i++) begin : g_lane
    logic [MW-1:0]        amag;
    logic signed [PW-1:0] bias;
    logic signed [PW-1:0] tsum;
    logic signed [PW-1:0] tshift;

    assign e_p[i] = $signed(mid_data[(mwm_pkg::WHEELS-1-i)*PW +: PW]);

    // in range: divide by 2^FB toward zero
    assign bias       = e_p[i][PW-1] ? PW'((1 << FB) - 1) : '0;
    assign tsum       = e_p[i] + bias;
    assign tshift     = tsum >>> FB;
    assign trunc_w[i] = tshift[7:0];

    // normalize: |p| * limit / max, one quotient bit per step
    assign amag       = e_p[i][PW-1] ? MW'(-e_p[i]) : MW'(e_p[i]);
    assign dvd_nxt[i] = DW'(amag) * DW'(power_limit);
    assign ge[i]      = (rem_r[i] >= dsh_r);
    assign div_w[i]   = neg_r[i] ? (8'd0 - {1'b0, quot_r[i]}) : {1'b0, quot_r[i]};

    always_ff @(posedge clk) begin
      if (load) begin
        rem_r[i]  <= dvd_nxt[i];
        quot_r[i] <= '0;
        neg_r[i]  <= e_p[i][PW-1];
      end else if (step) begin
        if (ge[i]) rem_r[i] <= rem_r[i] - dsh_r;
        quot_r[i] <= {quot_r[i][QB-2:0], ge[i]};
      end
    end
  end

  assign res_trunc.wheel_fl   = trunc_w[0];
  assign res_trunc.wheel_fr   = trunc_w[1];
  assign res_trunc.wheel_rl   = trunc_w[2];
  assign res_trunc.wheel_rr   = trunc_w[3];
  assign res_trunc.was_scaled = 1'b0;

  assign res_div.wheel_fl   = div_w[0];
  assign res_div.wheel_fr   = div_w[1];
  assign res_div.wheel_rl   = div_w[2];
  assign res_div.wheel_rr   = div_w[3];
  assign res_div.was_scaled = 1'b1;

  always_ff @(posedge clk) begin
    if (load) begin
      dsh_r  <= DW'(e_max) << (QB - 1);
      step_r <= SW'(QB - 1);
    end else if (step) begin
      dsh_r  <= dsh_r >> 1;
      step_r <= step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mwm_pkg::BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mid_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '0;
    load      = 1'b0;
    step      = 1'b0;
    unique case (state_r)
      mwm_pkg::BK_IDLE: begin
        if (!mid_empty) begin
          if (e_halt) begin
            if (!res_full) begin
              mid_pop  = 1'b1;
              res_push = 1'b1;
            end
          end else if (!e_scaled) begin
            res = res_trunc;
            if (!res_full) begin
              mid_pop  = 1'b1;
              res_push = 1'b1;
            end
          end else begin
            mid_pop   = 1'b1;
            load      = 1'b1;
            state_nxt = mwm_pkg::BK_DIV;
          end
        end
      end
      mwm_pkg::BK_DIV: begin
        step = 1'b1;
        if (step_r == '0) state_nxt = mwm_pkg::BK_PUSH;
      end
      mwm_pkg::BK_PUSH: begin
        res = res_div;
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = mwm_pkg::BK_IDLE;
        end
      end
      default: state_nxt = mwm_pkg::BK_IDLE;
    endcase
  end

endmodule

// ===== rtl/mecanum_wheel_mixer.sv =====
// Channel | Direction | Handshake         | Payload
// input   | in        | in_push / in_full | in_forward_axis, in_strafe_axis, in_rotate_axis,
//         |           |                   | in_halt
// result  | out       | out_empty/out_pop | out_front_left_out, out_front_right_out,
//         |           |                   | out_rear_left_out, out_rear_right_out, out_was_scaled
// config  | in        | cfg_we            | cfg_index, cfg_data
//
// One item can be taken every cycle while in_full is low; the front end is a two-stage pipeline
// into a 4-entry queue. Halted and in-range items leave the back end at one per cycle while the
// result queue has room; a normalized item holds the shared four-lane divider through load,
// 7 quotient steps and push, and the back end takes no new item until that result is pushed.
// Reset is synchronous: config registers return to defaults, both queues empty.
// in_full rises when the queue plus in-flight front stages would overflow; a stalled
// result queue backs up through the divider into the middle queue.
module mecanum_wheel_mixer #(
  parameter int FRACTION_BITS = mwm_pkg::FRACTION_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [7:0]                 in_forward_axis,
  input  logic signed [7:0]                 in_strafe_axis,
  input  logic signed [7:0]                 in_rotate_axis,
  input  logic                              in_halt,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [7:0]                 out_front_left_out,
  output logic signed [7:0]                 out_front_right_out,
  output logic signed [7:0]                 out_rear_left_out,
  output logic signed [7:0]                 out_rear_right_out,
  output logic                              out_was_scaled,
  input  logic                              cfg_we,
  input  logic [mwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mwm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int MIDW   = mwm_pkg::mid_w(FRACTION_BITS);
  localparam int RESW   = $bits(mwm_pkg::result_t);
  localparam int MCW    = $clog2(mwm_pkg::MID_DEPTH + 1);
  localparam int OCW    = $clog2(mwm_pkg::OUT_DEPTH + 1);

  mwm_pkg::cfg_t    cfg_r;
  logic             in_xfer;
  logic             mid_push;
  logic [MIDW-1:0]  mid_wdata;
  logic [MIDW-1:0]  mid_rdata;
  logic             mid_full;
  logic             mid_empty;
  logic             mid_pop;
  logic [MCW-1:0]   mid_cnt;
  logic [1:0]       in_flight;
  logic [MCW:0]     occupancy;
  logic             res_push;
  logic             res_full;
  mwm_pkg::result_t res;
  mwm_pkg::result_t head;
  logic [OCW-1:0]   out_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_band    <= mwm_pkg::DEAD_BAND_RST;
      cfg_r.forward_gain <= mwm_pkg::FORWARD_GAIN_RST;
      cfg_r.strafe_gain  <= mwm_pkg::STRAFE_GAIN_RST;
      cfg_r.rotate_gain  <= mwm_pkg::ROTATE_GAIN_RST;
      cfg_r.power_limit  <= mwm_pkg::POWER_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (mwm_pkg::cfg_reg_t'(cfg_index))
        mwm_pkg::REG_DEAD_BAND:    cfg_r.dead_band    <= cfg_data[6:0];
        mwm_pkg::REG_FORWARD_GAIN: cfg_r.forward_gain <= cfg_data;
        mwm_pkg::REG_STRAFE_GAIN:  cfg_r.strafe_gain  <= cfg_data;
        mwm_pkg::REG_ROTATE_GAIN:  cfg_r.rotate_gain  <= cfg_data;
        mwm_pkg::REG_POWER_LIMIT:  cfg_r.power_limit  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // credit check: the front pipeline never stalls, so reserve room for its contents
  assign occupancy = (MCW+1)'(mid_cnt) + (MCW+1)'(in_flight);
  assign in_full   = (occupancy >= (MCW+1)'(mwm_pkg::MID_DEPTH));
  assign in_xfer   = in_push && !in_full;

  mwm_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_xfer),
    .forward_axis (in_forward_axis),
    .strafe_axis  (in_strafe_axis),
    .rotate_axis  (in_rotate_axis),
    .halt         (in_halt),
    .cfg          (cfg_r),
    .out_valid    (mid_push),
    .out_data     (mid_wdata),
    .in_flight    (in_flight)
  );

  mwm_fifo #(
    .WIDTH(MIDW),
    .DEPTH(mwm_pkg::MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mid_push),
    .wr_data (mid_wdata),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_rdata),
    .empty   (mid_empty),
    .count   (mid_cnt)
  );

  mwm_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .mid_empty   (mid_empty),
    .mid_data    (mid_rdata),
    .mid_pop     (mid_pop),
    .power_limit (cfg_r.power_limit),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  mwm_fifo #(
    .WIDTH(RESW),
    .DEPTH(mwm_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (head),
    .empty   (out_empty),
    .count   (out_cnt)
  );

  assign out_front_left_out  = head.wheel_fl;
  assign out_front_right_out = head.wheel_fr;
  assign out_rear_left_out   = head.wheel_rl;
  assign out_rear_right_out  = head.wheel_rr;
  assign out_was_scaled      = head.was_scaled;

  // front pipeline must never push into a full middle queue
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    mid_push |-> !mid_full)
    else $error("middle queue overflow");

  // back end only pushes a result when the result queue has room
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (out_cnt < OCW'(mwm_pkg::OUT_DEPTH)))
    else $error("result pushed into full queue");

  // the back end only pops the middle queue while it holds data
  a_pop_routed: assert property (@(posedge clk) disable iff (!rst_n)
    mid_pop |-> !mid_empty)
    else $error("middle queue pop without data");

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

endmodule

// ===== tb/sv/tb_mecanum_wheel_mixer.sv =====
`timescale 1ns / 1ps

module tb_mecanum_wheel_mixer;

  localparam int FB           = mwm_pkg::FRACTION_BITS_DEF;
  localparam int IDX_W        = mwm_pkg::CFG_IDX_W;
  localparam int DATA_W       = mwm_pkg::CFG_DATA_W;
  localparam int DRAIN_CYCLES = 16;
  localparam int QUIET_LIMIT  = 2000;

  typedef struct {
    logic signed [7:0] fwd;
    logic signed [7:0] strafe;
    logic signed [7:0] rot;
    logic              halt;
  } stick_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  logic signed [7:0]     in_forward_axis = '0;
  logic signed [7:0]     in_strafe_axis = '0;
  logic signed [7:0]     in_rotate_axis = '0;
  logic                  in_halt = 1'b0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  logic signed [7:0]     out_front_left_out;
  logic signed [7:0]     out_front_right_out;
  logic signed [7:0]     out_rear_left_out;
  logic signed [7:0]     out_rear_right_out;
  logic                  out_was_scaled;
  logic                  cfg_we = 1'b0;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [DATA_W-1:0]     cfg_data = '0;

  stick_t           stick_q[$];
  mwm_pkg::result_t wheel_q[$];
  stick_t           cur_stick;
  mwm_pkg::cfg_t    regs;
  bit               idle_on = 1'b1;
  int               send_gap = 0;
  int               pop_gap = 0;
  int               quiet_cycles = 0;
  int               mismatches = 0;

  mecanum_wheel_mixer #(.FRACTION_BITS(FB)) uut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint magnitude(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // dead band, gain, then move from Q8 to Q(FB)
  function automatic longint scale_axis(logic signed [7:0] raw, logic [8:0] gain);
    longint v;
    v = longint'(raw);
    if (magnitude(v) < longint'(regs.dead_band)) v = 0;
    v = v * longint'(gain);
    if (FB >= 8) return v * (longint'(1) << (FB - 8));
    return v / (longint'(1) << (8 - FB));
  endfunction

  function automatic mwm_pkg::result_t mix_wheels(stick_t s);
    mwm_pkg::result_t res;
    longint  f, st, r, peak, lim;
    longint  p[4];
    longint  w[4];
    res = '0;
    if (s.halt) return res;
    f  = scale_axis(s.fwd, regs.forward_gain);
    st = scale_axis(s.strafe, regs.strafe_gain);
    r  = scale_axis(s.rot, regs.rotate_gain);
    p[0] = f + st + r;
    p[1] = f - st - r;
    p[2] = f - st + r;
    p[3] = f + st - r;
    peak = 0;
    foreach (p[i]) if (magnitude(p[i]) > peak) peak = magnitude(p[i]);
    lim = longint'(regs.power_limit);
    if (peak > (lim << FB)) begin
      res.was_scaled = 1'b1;
      foreach (p[i]) w[i] = (p[i] * lim) / peak;
    end else begin
      foreach (p[i]) w[i] = p[i] / (longint'(1) << FB);
    end
    res.wheel_fl = w[0][7:0];
    res.wheel_fr = w[1][7:0];
    res.wheel_rl = w[2][7:0];
    res.wheel_rr = w[3][7:0];
    return res;
  endfunction

  function automatic stick_t make_stick(int f, int s, int r, bit h);
    stick_t t;
    t.fwd    = 8'(f);
    t.strafe = 8'(s);
    t.rot    = 8'(r);
    t.halt   = h;
    return t;
  endfunction

  // bias toward the dead band edge and the rails, otherwise any byte
  function automatic logic signed [7:0] rand_axis();
    int v;
    case ($urandom_range(0, 7))
      0: begin
        v = int'(regs.dead_band) + $urandom_range(0, 4) - 2;
        if ($urandom_range(0, 1)) v = -v;
      end
      1: v = $urandom_range(0, 1) ? 127 : ($urandom_range(0, 1) ? -127 : -128);
      default: v = $urandom_range(0, 255);
    endcase
    return 8'(v);
  endfunction

  function automatic stick_t rand_stick();
    return make_stick(rand_axis(), rand_axis(), rand_axis(), $urandom_range(0, 7) == 0);
  endfunction

  task automatic check_field(input string name, input logic signed [7:0] want,
                             input logic signed [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (stick_q.size() != 0 || in_push || wheel_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      mwm_pkg::REG_DEAD_BAND:    regs.dead_band    = val[6:0];
      mwm_pkg::REG_FORWARD_GAIN: regs.forward_gain = val[8:0];
      mwm_pkg::REG_STRAFE_GAIN:  regs.strafe_gain  = val[8:0];
      mwm_pkg::REG_ROTATE_GAIN:  regs.rotate_gain  = val[8:0];
      mwm_pkg::REG_POWER_LIMIT:  regs.power_limit  = val[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // upper bits of the 7-bit registers carry junk; spare indexes must not land anywhere
  task automatic load_setting(input mwm_pkg::cfg_t c);
    logic [1:0] junk;
    junk = 2'($urandom);
    write_reg(mwm_pkg::REG_DEAD_BAND, {junk, c.dead_band});
    write_reg(mwm_pkg::REG_FORWARD_GAIN, c.forward_gain);
    write_reg(mwm_pkg::REG_STRAFE_GAIN, c.strafe_gain);
    write_reg(mwm_pkg::REG_ROTATE_GAIN, c.rotate_gain);
    junk = 2'($urandom);
    write_reg(mwm_pkg::REG_POWER_LIMIT, {junk, c.power_limit});
    for (int k = int'(mwm_pkg::REG_POWER_LIMIT) + 1; k < 2 ** IDX_W; k++)
      write_reg(IDX_W'(k), DATA_W'($urandom));
  endtask

  task automatic run_phase(input mwm_pkg::cfg_t c, input int n);
    wait_idle();
    load_setting(c);
    @(negedge clk);
    repeat (n) stick_q.push_back(rand_stick());
  endtask

  function automatic mwm_pkg::cfg_t rand_setting();
    mwm_pkg::cfg_t c;
    c.dead_band    = 7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                  : $urandom_range(0, 20));
    c.forward_gain = 9'($urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                  : $urandom_range(0, 256));
    c.strafe_gain  = 9'($urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                  : $urandom_range(0, 256));
    c.rotate_gain  = 9'($urandom_range(0, 3) == 0 ? $urandom_range(0, 511)
                                                  : $urandom_range(0, 256));
    c.power_limit  = 7'($urandom_range(0, 7) == 0 ? $urandom_range(0, 127)
                                                  : $urandom_range(1, 127));
    return c;
  endfunction

  initial begin
    regs.dead_band    = mwm_pkg::DEAD_BAND_RST;
    regs.forward_gain = mwm_pkg::FORWARD_GAIN_RST;
    regs.strafe_gain  = mwm_pkg::STRAFE_GAIN_RST;
    regs.rotate_gain  = mwm_pkg::ROTATE_GAIN_RST;
    regs.power_limit  = mwm_pkg::POWER_LIMIT_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: rails, dead band edge, halt, pure and mixed motion
    stick_q.push_back(make_stick(0, 0, 0, 0));
    stick_q.push_back(make_stick(127, 0, 0, 0));
    stick_q.push_back(make_stick(-128, 0, 0, 0));
    stick_q.push_back(make_stick(0, 127, 0, 0));
    stick_q.push_back(make_stick(0, -127, 0, 0));
    stick_q.push_back(make_stick(0, 0, 127, 0));
    stick_q.push_back(make_stick(0, 0, -128, 0));
    stick_q.push_back(make_stick(127, 127, 127, 0));
    stick_q.push_back(make_stick(-128, -128, -128, 0));
    stick_q.push_back(make_stick(127, -128, 127, 0));
    stick_q.push_back(make_stick(9, -9, 9, 0));
    stick_q.push_back(make_stick(10, -10, 10, 0));
    stick_q.push_back(make_stick(127, 127, 127, 1));
    stick_q.push_back(make_stick(-128, 5, -77, 1));
    stick_q.push_back(make_stick(40, 30, 20, 0));
    stick_q.push_back(make_stick(100, -100, 0, 0));
    stick_q.push_back(make_stick(-1, 1, -1, 0));
    stick_q.push_back(make_stick(64, -32, 16, 0));

    // dead band off, unity gains; then the top of the dead band and gain ranges with a limit of one
    run_phase('{dead_band: 7'd0, forward_gain: 9'd256, strafe_gain: 9'd256,
                rotate_gain: 9'd256, power_limit: 7'd127}, 40);
    run_phase('{dead_band: 7'd127, forward_gain: 9'd511, strafe_gain: 9'd511,
                rotate_gain: 9'd511, power_limit: 7'd1}, 40);
    // zero gains and zero limit: all powers zero, never flagged
    run_phase('{dead_band: 7'd0, forward_gain: 9'd0, strafe_gain: 9'd0,
                rotate_gain: 9'd0, power_limit: 7'd0}, 30);
    // zero limit with live axes: everything collapses to zero, nonzero mixes flagged
    run_phase('{dead_band: 7'd3, forward_gain: 9'd300, strafe_gain: 9'd100,
                rotate_gain: 9'd400, power_limit: 7'd0}, 30);
    run_phase('{dead_band: 7'd64, forward_gain: 9'd128, strafe_gain: 9'd1,
                rotate_gain: 9'd257, power_limit: 7'd100}, 40);
    repeat (4) run_phase(rand_setting(), 45);

    wait_idle();
    idle_on = 1'b0;
    run_phase('{dead_band: mwm_pkg::DEAD_BAND_RST, forward_gain: mwm_pkg::FORWARD_GAIN_RST,
                strafe_gain: mwm_pkg::STRAFE_GAIN_RST, rotate_gain: mwm_pkg::ROTATE_GAIN_RST,
                power_limit: mwm_pkg::POWER_LIMIT_RST}, 40);
    wait_idle();

    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // driver: prediction is taken at the input transfer, config is static then
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (in_push && in_full) begin
      // hold the item until it is taken
    end else begin
      if (in_push) wheel_q.push_back(mix_wheels(cur_stick));
      if (send_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
        send_gap = $urandom_range(1, 16);
      if (send_gap != 0 || stick_q.size() == 0) begin
        if (send_gap != 0) send_gap--;
        in_push <= 1'b0;
      end else begin
        cur_stick = stick_q.pop_front();
        in_push         <= 1'b1;
        in_forward_axis <= cur_stick.fwd;
        in_strafe_axis  <= cur_stick.strafe;
        in_rotate_axis  <= cur_stick.rot;
        in_halt         <= cur_stick.halt;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    mwm_pkg::result_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (wheel_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          mismatches++;
        end else begin
          want = wheel_q.pop_front();
          check_field("front_left_out", want.wheel_fl, out_front_left_out);
          check_field("front_right_out", want.wheel_fr, out_front_right_out);
          check_field("rear_left_out", want.wheel_rl, out_rear_left_out);
          check_field("rear_right_out", want.wheel_rr, out_rear_right_out);
          check_field("was_scaled", {7'd0, want.was_scaled}, {7'd0, out_was_scaled});
        end
      end
      if (pop_gap == 0 && idle_on && $urandom_range(0, 9) == 0)
        pop_gap = $urandom_range(1, 16);
      if (pop_gap != 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule

// ===== mecanum_wheel_mixer.f =====
rtl/mwm_pkg.sv
rtl/mwm_fifo.sv
rtl/mwm_front.sv
rtl/mwm_back.sv
rtl/mecanum_wheel_mixer.sv
tb/sv/tb_mecanum_wheel_mixer.sv
